@@ rtl/psm_pkg.sv @@
// ----------------------------------------------------------------------------
// psm_pkg: shared types and constants of the PCM sound mixer
// Opcodes, controller states, command and status records, mix constants.
// ----------------------------------------------------------------------------
`default_nettype none

package psm_pkg;

  localparam int VOICES       = 4;
  localparam int VOICE_W      = 2;
  localparam int FRAC_BITS    = 10;
  localparam int PWM_PERIOD   = 1024;
  localparam int SAMPLE_BYTES = 65536;
  localparam int MEM_AW       = 16;
  localparam int DUTY_W       = 10;
  localparam int ACC_W        = 32;
  localparam int IL_W         = 29;
  localparam int SC_W         = IL_W + 16;
  localparam int REM_W        = 18;
  localparam int IN_W         = 112;
  localparam int OUT_W        = 32;

  localparam logic signed [ACC_W-1:0] MIX_BIAS =
    ACC_W'((PWM_PERIOD / 2) * (1 << FRAC_BITS));
  localparam logic signed [ACC_W-1:0] DITHER_LO = ACC_W'((1 << FRAC_BITS) / 4);
  localparam logic signed [ACC_W-1:0] DITHER_HI = ACC_W'(((1 << FRAC_BITS) * 3) / 4);
  localparam logic signed [ACC_W-1:0] DUTY_MAX  = ACC_W'(PWM_PERIOD - 1);
  localparam logic signed [15:0]      REP_STREAM = -16'sd2;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_WRITE = 3'd1,
    OP_START = 3'd2,
    OP_NEXT  = 3'd3,
    OP_STOP  = 3'd4,
    OP_SPEED = 3'd5,
    OP_GAINS = 3'd6
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_VCHECK,
    S_READ,
    S_DRAIN,
    S_INTERP,
    S_SCALE,
    S_ACCUM,
    S_UPDATE,
    S_VNEXT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic mem_write;
    logic voice_op;
    logic tick_init;
    logic rd_issue;
    logic interp;
    logic scale;
    logic accum;
    logic update;
    logic vidx_inc;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_write;
    logic is_voice_op;
    logic is_tick;
    logic voice_active;
    logic last_voice;
    logic rd_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/psm_ram.sv @@
// ----------------------------------------------------------------------------
// psm_ram: generic single-clock RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module psm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/psm_ctrl.sv @@
// ----------------------------------------------------------------------------
// psm_ctrl: sequencer of the PCM sound mixer
// Steps each command and each voice of a tick through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module psm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_fire,
  input  wire psm_pkg::status_t  st,
  output logic                   in_ready,
  output psm_pkg::cmd_t          cmd
);

  psm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      psm_pkg::S_IDLE: begin
        // hold off the sender while reset is asserted
        in_ready = !rst;
        if (in_fire && in_ready) begin
          cmd.load   = 1'b1;
          state_next = psm_pkg::S_DECODE;
        end
      end
      psm_pkg::S_DECODE: begin
        if (st.is_write) begin
          cmd.mem_write = 1'b1;
          state_next    = psm_pkg::S_IDLE;
        end else if (st.is_voice_op) begin
          cmd.voice_op = 1'b1;
          state_next   = psm_pkg::S_IDLE;
        end else if (st.is_tick) begin
          cmd.tick_init = 1'b1;
          state_next    = psm_pkg::S_VCHECK;
        end else begin
          state_next = psm_pkg::S_IDLE;
        end
      end
      psm_pkg::S_VCHECK: begin
        state_next = st.voice_active ? psm_pkg::S_READ : psm_pkg::S_VNEXT;
      end
      psm_pkg::S_READ: begin
        cmd.rd_issue = 1'b1;
        if (st.rd_last) begin
          state_next = psm_pkg::S_DRAIN;
        end
      end
      psm_pkg::S_DRAIN: begin
        state_next = psm_pkg::S_INTERP;
      end
      psm_pkg::S_INTERP: begin
        cmd.interp = 1'b1;
        state_next = psm_pkg::S_SCALE;
      end
      psm_pkg::S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = psm_pkg::S_ACCUM;
      end
      psm_pkg::S_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = psm_pkg::S_UPDATE;
      end
      psm_pkg::S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = psm_pkg::S_VNEXT;
      end
      psm_pkg::S_VNEXT: begin
        if (st.last_voice) begin
          state_next = psm_pkg::S_FINISH;
        end else begin
          cmd.vidx_inc = 1'b1;
          state_next   = psm_pkg::S_VCHECK;
        end
      end
      psm_pkg::S_FINISH: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = psm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = psm_pkg::S_IDLE;
      end
    endcase
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_ready |=> state == psm_pkg::S_DECODE)
    else $error("accepted item not decoded");

  a_last_voice_finishes: assert property (@(posedge clk) disable iff (rst)
    state == psm_pkg::S_VNEXT && st.last_voice |=> state == psm_pkg::S_FINISH)
    else $error("tick did not finish after last voice");

  a_finish_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> st.out_free)
    else $error("result loaded into a full output register");

endmodule

`default_nettype wire

@@ rtl/psm_datapath.sv @@
// ----------------------------------------------------------------------------
// psm_datapath: voice state, sample memory and mix arithmetic
// Executes the sequencer's commands and holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psm_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire psm_pkg::cmd_t              cmd,
  output psm_pkg::status_t                st,
  input  wire logic [psm_pkg::IN_W-1:0]   in_data,
  input  wire logic [2:0]                 in_user,
  input  wire logic                       swap,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [psm_pkg::OUT_W-1:0]       out_data
);

  localparam int FB = psm_pkg::FRAC_BITS;

  // latched command
  psm_pkg::opcode_t              in_op;
  logic [psm_pkg::VOICE_W-1:0]   in_voice;
  logic [15:0]                   in_addr;
  logic [7:0]                    in_byte;
  logic [1:0]                    in_fmt;
  logic [15:0]                   in_cnt;
  logic [15:0]                   in_inc;
  logic signed [15:0]            in_gl, in_gr, in_rep;

  // voice state
  logic [15:0]                   v_addr   [psm_pkg::VOICES];
  logic signed [psm_pkg::REM_W-1:0] v_rem [psm_pkg::VOICES];
  logic [FB-1:0]                 v_phase  [psm_pkg::VOICES];
  logic [15:0]                   v_inc    [psm_pkg::VOICES];
  logic signed [15:0]            v_gl     [psm_pkg::VOICES];
  logic signed [15:0]            v_gr     [psm_pkg::VOICES];
  logic [1:0]                    v_fmt    [psm_pkg::VOICES];
  logic signed [15:0]            v_rep    [psm_pkg::VOICES];
  logic [15:0]                   v_nbaddr [psm_pkg::VOICES];
  logic [15:0]                   v_nbcnt  [psm_pkg::VOICES];
  logic                          dither;

  logic [psm_pkg::VOICE_W-1:0]   vidx;
  logic [2:0]                    rd_cnt, cap_sel;
  logic                          cap_en;
  logic [7:0]                    b0 [4];
  logic [7:0]                    b1 [4];
  logic [7:0]                    rdata;

  logic signed [psm_pkg::IL_W-1:0]  il_l, il_r;
  logic signed [psm_pkg::SC_W-1:0]  sc_l, sc_r;
  logic signed [psm_pkg::ACC_W-1:0] acc_l, acc_r;

  // current voice view
  logic [15:0]            a0, a1, fstep, rd_addr;
  logic [1:0]             fmt, fsh;
  logic signed [16:0]     l0, l1, r0, r1;
  logic signed [17:0]     dl, dr;
  logic signed [psm_pkg::IL_W-1:0] phase_x;
  logic signed [psm_pkg::IL_W-1:0] pd_l, pd_r, il_l_c, il_r_c;
  logic signed [psm_pkg::SC_W-1:0] sh_l, sh_r;

  // advance
  logic [16:0]            ph;
  logic [6:0]             k;
  logic [15:0]            step, over, addr1, naddr;
  logic signed [psm_pkg::REM_W-1:0] rem1, nrem;
  logic                   chain;
  logic signed [15:0]     rep_n;

  // output math
  logic signed [psm_pkg::ACC_W-1:0] sum_l, sum_r, q_l, q_r;
  logic [psm_pkg::DUTY_W-1:0]       d_l, d_r;
  logic [3:0]                       pmask, emask;

  assign fmt   = v_fmt[vidx];
  assign fsh   = (fmt == 2'd0) ? 2'd0 : ((fmt == 2'd3) ? 2'd2 : 2'd1);
  assign fstep = 16'd1 << fsh;
  assign a0    = v_addr[vidx];
  assign a1    = (v_rem[vidx] > 18'sd1) ? a0 + fstep : a0;
  assign rd_addr = (rd_cnt[2] ? a1 : a0) + {14'd0, rd_cnt[1:0]};

  psm_ram #(.WIDTH(8), .DEPTH(psm_pkg::SAMPLE_BYTES)) u_mem (
    .clk   (clk),
    .we    (cmd.mem_write),
    .waddr (in_addr[psm_pkg::MEM_AW-1:0]),
    .wdata (in_byte),
    .raddr (rd_addr[psm_pkg::MEM_AW-1:0]),
    .rdata (rdata)
  );

  // unpack frames into channel samples
  always_comb begin
    if (fmt[1]) begin
      l0 = 17'(signed'({b0[1], b0[0]}));
      l1 = 17'(signed'({b1[1], b1[0]}));
      r0 = fmt[0] ? 17'(signed'({b0[3], b0[2]})) : l0;
      r1 = fmt[0] ? 17'(signed'({b1[3], b1[2]})) : l1;
    end else begin
      l0 = $signed({9'd0, b0[0]}) - 17'sd128;
      l1 = $signed({9'd0, b1[0]}) - 17'sd128;
      r0 = fmt[0] ? $signed({9'd0, b0[1]}) - 17'sd128 : l0;
      r1 = fmt[0] ? $signed({9'd0, b1[1]}) - 17'sd128 : l1;
    end
  end

  assign dl      = 18'(l1) - 18'(l0);
  assign dr      = 18'(r1) - 18'(r0);
  assign phase_x = psm_pkg::IL_W'($signed({1'b0, v_phase[vidx]}));
  assign pd_l    = psm_pkg::IL_W'(dl) * phase_x;
  assign pd_r    = psm_pkg::IL_W'(dr) * phase_x;
  assign il_l_c  = (psm_pkg::IL_W'(l0) <<< FB) + pd_l;
  assign il_r_c  = (psm_pkg::IL_W'(r0) <<< FB) + pd_r;
  assign sh_l    = fmt[1] ? (sc_l >>> 16) : (sc_l >>> 8);
  assign sh_r    = fmt[1] ? (sc_r >>> 16) : (sc_r >>> 8);

  // phase advance and buffer chaining
  assign ph    = {7'd0, v_phase[vidx]} + {1'b0, v_inc[vidx]};
  assign k     = ph[16:FB];
  assign step  = {9'd0, k} << fsh;
  assign addr1 = a0 + step;
  assign rem1  = v_rem[vidx] - $signed({11'd0, k});
  assign chain = (rem1 <= 0) && (v_rep[vidx] != 16'sd0) && (v_nbcnt[vidx] != 16'd0);
  assign over  = 16'(-rem1);
  assign naddr = v_nbaddr[vidx] + (over << fsh);
  assign nrem  = rem1 + $signed({2'd0, v_nbcnt[vidx]});
  assign rep_n = (v_rep[vidx] > 16'sd0) ? v_rep[vidx] - 16'sd1 : v_rep[vidx];

  // final mix: dither, scale down, clamp
  always_comb begin
    sum_l = acc_l + (dither ? psm_pkg::DITHER_HI : psm_pkg::DITHER_LO);
    sum_r = acc_r + (dither ? psm_pkg::DITHER_HI : psm_pkg::DITHER_LO);
    q_l   = sum_l >>> FB;
    q_r   = sum_r >>> FB;
    if (q_l < 0) d_l = '0;
    else if (q_l > psm_pkg::DUTY_MAX) d_l = psm_pkg::DUTY_W'(psm_pkg::DUTY_MAX);
    else d_l = q_l[psm_pkg::DUTY_W-1:0];
    if (q_r < 0) d_r = '0;
    else if (q_r > psm_pkg::DUTY_MAX) d_r = psm_pkg::DUTY_W'(psm_pkg::DUTY_MAX);
    else d_r = q_r[psm_pkg::DUTY_W-1:0];
    for (int i = 0; i < 4; i++) begin
      pmask[i] = v_rem[i] > 0;
      emask[i] = v_nbcnt[i] == 16'd0;
    end
  end

  always_comb begin
    st.is_write     = in_op == psm_pkg::OP_WRITE;
    st.is_voice_op  = (in_op == psm_pkg::OP_START) || (in_op == psm_pkg::OP_NEXT) ||
                      (in_op == psm_pkg::OP_STOP) || (in_op == psm_pkg::OP_SPEED) ||
                      (in_op == psm_pkg::OP_GAINS);
    st.is_tick      = in_op == psm_pkg::OP_TICK;
    st.voice_active = v_rem[vidx] > 0;
    st.last_voice   = vidx == psm_pkg::VOICE_W'(psm_pkg::VOICES - 1);
    st.rd_last      = rd_cnt == 3'd7;
    st.out_free     = !out_valid || out_ready;
  end

  // payload latches
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_op    <= psm_pkg::opcode_t'(in_user);
      in_voice <= in_data[1:0];
      in_addr  <= in_data[17:2];
      in_byte  <= in_data[25:18];
      in_fmt   <= in_data[27:26];
      in_cnt   <= in_data[43:28];
      in_inc   <= in_data[59:44];
      in_gl    <= in_data[75:60];
      in_gr    <= in_data[91:76];
      in_rep   <= in_data[107:92];
    end
    if (cap_en) begin
      if (cap_sel[2]) b1[cap_sel[1:0]] <= rdata;
      else b0[cap_sel[1:0]] <= rdata;
    end
    if (cmd.interp) begin
      il_l <= il_l_c;
      il_r <= il_r_c;
    end
    if (cmd.scale) begin
      sc_l <= il_l * v_gl[vidx];
      sc_r <= il_r * v_gr[vidx];
    end
    if (cmd.finish) begin
      out_data <= {4'd0, emask, pmask, swap ? d_l : d_r, swap ? d_r : d_l};
    end
  end

  // control and voice state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < psm_pkg::VOICES; i++) begin
        v_addr[i]   <= '0;
        v_rem[i]    <= '0;
        v_phase[i]  <= '0;
        v_inc[i]    <= '0;
        v_gl[i]     <= '0;
        v_gr[i]     <= '0;
        v_fmt[i]    <= '0;
        v_rep[i]    <= '0;
        v_nbaddr[i] <= '0;
        v_nbcnt[i]  <= '0;
      end
      dither    <= 1'b0;
      vidx      <= '0;
      rd_cnt    <= '0;
      cap_sel   <= '0;
      cap_en    <= 1'b0;
      acc_l     <= '0;
      acc_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      cap_en  <= cmd.rd_issue;
      cap_sel <= rd_cnt;
      if (cmd.rd_issue) rd_cnt <= rd_cnt + 3'd1;
      if (cmd.tick_init) begin
        acc_l  <= psm_pkg::MIX_BIAS;
        acc_r  <= psm_pkg::MIX_BIAS;
        vidx   <= '0;
        rd_cnt <= '0;
      end
      if (cmd.vidx_inc) vidx <= vidx + 1'b1;
      if (cmd.accum) begin
        acc_l <= acc_l + psm_pkg::ACC_W'(sh_l);
        acc_r <= acc_r + psm_pkg::ACC_W'(sh_r);
      end
      if (cmd.update) begin
        v_phase[vidx] <= ph[FB-1:0];
        if (chain) begin
          v_rep[vidx]  <= rep_n;
          v_addr[vidx] <= naddr;
          v_rem[vidx]  <= nrem;
          if (rep_n == psm_pkg::REP_STREAM) begin
            v_nbaddr[vidx] <= '0;
            v_nbcnt[vidx]  <= '0;
          end
        end else begin
          v_addr[vidx] <= addr1;
          v_rem[vidx]  <= rem1;
        end
      end
      if (cmd.voice_op) begin
        case (in_op)
          psm_pkg::OP_START: begin
            v_fmt[in_voice]   <= in_fmt;
            v_gl[in_voice]    <= in_gl;
            v_gr[in_voice]    <= in_gr;
            v_rep[in_voice]   <= in_rep;
            v_inc[in_voice]   <= in_inc;
            v_phase[in_voice] <= '0;
            v_addr[in_voice]  <= in_addr;
            v_rem[in_voice]   <= $signed({2'd0, in_cnt});
            if (in_rep != 16'sd0 && in_rep != psm_pkg::REP_STREAM) begin
              v_nbaddr[in_voice] <= in_addr;
              v_nbcnt[in_voice]  <= in_cnt;
            end else begin
              v_nbaddr[in_voice] <= '0;
              v_nbcnt[in_voice]  <= '0;
            end
          end
          psm_pkg::OP_NEXT: begin
            if (!(v_rem[in_voice] > 0 && v_nbaddr[in_voice] == in_addr &&
                  v_nbcnt[in_voice] == in_cnt)) begin
              if (v_rem[in_voice] <= 0) begin
                v_addr[in_voice] <= in_addr;
                v_rem[in_voice]  <= $signed({2'd0, in_cnt});
              end
              v_nbaddr[in_voice] <= in_addr;
              v_nbcnt[in_voice]  <= in_cnt;
            end
          end
          psm_pkg::OP_STOP: begin
            v_nbaddr[in_voice] <= '0;
            v_nbcnt[in_voice]  <= '0;
            v_rep[in_voice]    <= '0;
            v_rem[in_voice]    <= '0;
          end
          psm_pkg::OP_SPEED: v_inc[in_voice] <= in_inc;
          psm_pkg::OP_GAINS: begin
            v_gl[in_voice] <= in_gl;
            v_gr[in_voice] <= in_gr;
          end
          default: ;
        endcase
      end
      if (cmd.finish) begin
        dither    <= ~dither;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/pcm_sound_mixer_core.sv @@
// ----------------------------------------------------------------------------
// pcm_sound_mixer_core: four-voice stereo PCM mixer with interpolation
// Sequencer plus datapath; one output sample per tick command.
// ----------------------------------------------------------------------------
// Usage:
//  - Commands enter on the s_ channel: opcode in s_tuser, arguments in
//    s_tdata. Sample byte writes and voice set-up give no output; a tick
//    mixes every playing voice and emits one item on the m_ channel.
//  - Each item is taken in the idle state, decoded the next cycle; a
//    command other than a tick completes in the decode state.
//  - A tick walks the voices one by one: a silent voice is skipped, a
//    playing one takes 8 byte reads through the single sample memory
//    read port, then interpolate, scale, accumulate, advance; decode
//    comes before the voices and the final mix after them.
//  - The result sits in an output register; the next command is accepted
//    while it waits. A following tick holds in its final step until the
//    receiver takes the previous result.
//  - Reset clears all voices, the dither phase and swap_outputs. The
//    sample memory is not cleared and must be written before it is played.
//  - Write swap_outputs via cfg_valid/cfg_data only while idle (unenforced).
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_sound_mixer_core (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  // voice[1:0] address[17:2] data_byte[25:18] sample_format[27:26]
  // frame_count[43:28] step_increment[59:44] gain_left[75:60]
  // gain_right[91:76] repeat_count[107:92], zero fill above
  input  wire logic [psm_pkg::IN_W-1:0] s_tdata,
  // opcode[2:0]
  input  wire logic [2:0]               s_tuser,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // out_first[9:0] out_second[19:10] playing_mask[23:20]
  // next_empty_mask[27:24], zero fill above
  output logic [psm_pkg::OUT_W-1:0]     m_tdata,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic                     cfg_data
);

  psm_pkg::cmd_t    cmd;
  psm_pkg::status_t st;
  logic             swap_outputs;

  // the register is writable whenever reset is released
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      swap_outputs <= 1'b0;
    end else if (cfg_valid) begin
      swap_outputs <= cfg_data;
    end
  end

  psm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (s_tvalid),
    .st       (st),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  psm_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_data   (s_tdata),
    .in_user   (s_tuser),
    .swap      (swap_outputs),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire
